[hw/rtl/motor_feedback_frame_decoder_core_macros.svh]
// Assertion helpers for the motor feedback decoder.
// Each macro expects clk_i and rst_ni in scope.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_CORE_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define MFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MFD_ASSERT(lbl, prop, msg)

`define MFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/mfd_pkg.sv]
package mfd_pkg;

  // Field widths
  localparam int unsigned CFG_W     = 24;  // range registers, signed Q8.16
  localparam int unsigned THR_W     = 23;  // wrap threshold
  localparam int unsigned VAL_W     = 26;  // scaled value before truncation
  localparam int unsigned SPAN_W    = 25;  // max - min
  localparam int unsigned TURN_W    = 16;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned FRAME_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned VEL_BITS_DEF = 12;
  localparam int unsigned TRQ_BITS     = 12;

  // Scaler pipeline depth
  localparam int unsigned SCL_LAT = 4;

  // Register reset values
  localparam logic signed [CFG_W-1:0] POS_MIN_RST = -24'sd819200;
  localparam logic signed [CFG_W-1:0] POS_MAX_RST =  24'sd819200;
  localparam logic signed [CFG_W-1:0] VEL_MIN_RST = -24'sd1966080;
  localparam logic signed [CFG_W-1:0] VEL_MAX_RST =  24'sd1966080;
  localparam logic signed [CFG_W-1:0] TRQ_MIN_RST = -24'sd655360;
  localparam logic signed [CFG_W-1:0] TRQ_MAX_RST =  24'sd655360;
  localparam logic [THR_W-1:0]        THR_RST     =  23'd819200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_MIN  = 3'd0,
    CFG_POS_MAX  = 3'd1,
    CFG_VEL_MIN  = 3'd2,
    CFG_VEL_MAX  = 3'd3,
    CFG_TRQ_MIN  = 3'd4,
    CFG_TRQ_MAX  = 3'd5,
    CFG_WRAP_THR = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_FEEDBACK = 1'b0,
    MODE_CALIB    = 1'b1
  } mode_e;

  // Frame bytes that travel alongside the scalers
  typedef struct packed {
    mode_e      mode;
    logic [7:0] byte0;
    logic [7:0] mos_temp;
    logic [7:0] rotor_temp;
  } side_t;

  // Result item, motor_id in the lowest bits
  typedef struct packed {
    logic [TOTAL_W-1:0] total_angle;
    logic [TURN_W-1:0]  turn_count;
    logic [7:0]         rotor_temp;
    logic [7:0]         mos_temp;
    logic [CFG_W-1:0]   torque;
    logic [CFG_W-1:0]   velocity;
    logic [CFG_W-1:0]   position;
    logic [3:0]         error_code;
    logic [3:0]         motor_id;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

[hw/rtl/motor_feedback_frame_decoder_core.sv]
// Pipeline: input reg, 4 scaler stages, turn tracking, turn*span multiply, output add.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds only while the output register is full and not taken.
// Reset (rst_ni low, async): valid bits, turn counter and last position clear,
//   range registers return to their defaults. Data registers are not reset.
`include "motor_feedback_frame_decoder_core_macros.svh"

module motor_feedback_frame_decoder_core
  import mfd_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF,  // 8..16
  parameter int unsigned VEL_BITS = VEL_BITS_DEF   // 8..12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,

  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [FRAME_W-1:0]   s_axis_tdata,   // [63:0] frame
  input  logic [0:0]           s_axis_tuser,   // [0] mode

  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RES_W-1:0]     m_axis_tdata    // [3:0] motor_id, [7:4] error_code,
                                               // [31:8] position, [55:32] velocity,
                                               // [79:56] torque, [87:80] mos_temp,
                                               // [95:88] rotor_temp, [111:96] turn_count,
                                               // [159:112] total_angle
);

  // ---------------------------------------------------------------------------
  // Range registers. Writes must land only while idle (the block does not enforce this), so
  // the datapath reads them directly; spans derived from them are re-registered every cycle.
  // ---------------------------------------------------------------------------
  logic signed [CFG_W-1:0] pos_min_q, pos_max_q;
  logic signed [CFG_W-1:0] vel_min_q, vel_max_q;
  logic signed [CFG_W-1:0] trq_min_q, trq_max_q;
  logic [THR_W-1:0]        thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q <= POS_MIN_RST;
      pos_max_q <= POS_MAX_RST;
      vel_min_q <= VEL_MIN_RST;
      vel_max_q <= VEL_MAX_RST;
      trq_min_q <= TRQ_MIN_RST;
      trq_max_q <= TRQ_MAX_RST;
      thr_q     <= THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_MIN:  pos_min_q <= cfg_data_i;
        CFG_POS_MAX:  pos_max_q <= cfg_data_i;
        CFG_VEL_MIN:  vel_min_q <= cfg_data_i;
        CFG_VEL_MAX:  vel_max_q <= cfg_data_i;
        CFG_TRQ_MIN:  trq_min_q <= cfg_data_i;
        CFG_TRQ_MAX:  trq_max_q <= cfg_data_i;
        CFG_WRAP_THR: thr_q     <= cfg_data_i[THR_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // position span for the total angle
  logic signed [SPAN_W-1:0] pspan_q;

  always_ff @(posedge clk_i) begin
    pspan_q <= SPAN_W'(pos_max_q) - SPAN_W'(pos_min_q);
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: everything moves unless a result sits unclaimed.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // input register
  logic               in_v_q;
  mode_e              in_mode_q;
  logic [FRAME_W-1:0] in_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_mode_q  <= mode_e'(s_axis_tuser[0]);
      in_frame_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Scalers. Byte 1..2 position, byte 3 + high nibble of byte 4 velocity,
  // low nibble of byte 4 + byte 5 torque. Narrow widths take the top bits.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] pos_val, vel_val, trq_val;

  mfd_scale #(
    .BITS (POS_BITS)
  ) u_pos_scale (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (in_frame_q[55 -: POS_BITS]),
    .lo_i  (pos_min_q),
    .hi_i  (pos_max_q),
    .val_o (pos_val)
  );

  mfd_scale #(
    .BITS (VEL_BITS)
  ) u_vel_scale (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (in_frame_q[39 -: VEL_BITS]),
    .lo_i  (vel_min_q),
    .hi_i  (vel_max_q),
    .val_o (vel_val)
  );

  mfd_scale #(
    .BITS (TRQ_BITS)
  ) u_trq_scale (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (in_frame_q[27 -: TRQ_BITS]),
    .lo_i  (trq_min_q),
    .hi_i  (trq_max_q),
    .val_o (trq_val)
  );

  // side bytes and valid ride along with the scalers
  logic [SCL_LAT-1:0] sv_q;
  side_t              side_q [SCL_LAT];
  side_t              side_in;

  assign side_in = '{mode:       in_mode_q,
                     byte0:      in_frame_q[63:56],
                     mos_temp:   in_frame_q[15:8],
                     rotor_temp: in_frame_q[7:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[SCL_LAT-2:0], in_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < SCL_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Turn tracking: jump below -thr counts up, above +thr counts down.
  // Calibration clears both the counter and the last position.
  // ---------------------------------------------------------------------------
  side_t                   scl_side;
  logic                    scl_v;
  logic [TURN_W-1:0]       turns_d, turns_q;
  logic signed [VAL_W-1:0] prev_d, prev_q;
  logic signed [VAL_W:0]   diff;
  logic signed [VAL_W:0]   thr_s;

  assign scl_side = side_q[SCL_LAT-1];
  assign scl_v    = sv_q[SCL_LAT-1];
  assign diff     = (VAL_W+1)'(pos_val) - (VAL_W+1)'(prev_q);
  assign thr_s    = $signed((VAL_W+1)'(thr_q));

  always_comb begin
    turns_d = turns_q;
    prev_d  = pos_val;
    if (scl_side.mode == MODE_CALIB) begin
      turns_d = '0;
      prev_d  = '0;
    end else if (diff < -thr_s) begin
      turns_d = turns_q + TURN_W'(1);
    end else if (diff > thr_s) begin
      turns_d = turns_q - TURN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turns_q <= '0;
      prev_q  <= '0;
    end else if (en && scl_v) begin
      turns_q <= turns_d;
      prev_q  <= prev_d;
    end
  end

  logic                    trk_v_q;
  side_t                   trk_side_q;
  logic signed [VAL_W-1:0] trk_pos_q;
  logic [CFG_W-1:0]        trk_vel_q, trk_trq_q;

  // ---------------------------------------------------------------------------
  // Multiply and output stages
  // ---------------------------------------------------------------------------
  logic                             mul_v_q;
  side_t                            mul_side_q;
  logic signed [VAL_W-1:0]          mul_pos_q;
  logic [CFG_W-1:0]                 mul_vel_q, mul_trq_q;
  logic [TURN_W-1:0]                mul_turns_q;
  logic signed [TURN_W+SPAN_W-1:0]  mul_prod_q;

  result_t          res_d, out_q;
  logic             out_mode_q;
  logic [TOTAL_W-1:0] total;

  assign total = TOTAL_W'(mul_prod_q) + TOTAL_W'(mul_pos_q);

  always_comb begin
    res_d.motor_id    = mul_side_q.byte0[3:0];
    res_d.error_code  = mul_side_q.byte0[7:4];
    res_d.position    = mul_pos_q[CFG_W-1:0];
    res_d.velocity    = mul_vel_q;
    res_d.torque      = mul_trq_q;
    res_d.mos_temp    = mul_side_q.mos_temp;
    res_d.rotor_temp  = mul_side_q.rotor_temp;
    res_d.turn_count  = mul_turns_q;
    res_d.total_angle = total;
    if (mul_side_q.mode == MODE_CALIB) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_v_q <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      trk_v_q <= scl_v;
      mul_v_q <= trk_v_q;
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trk_side_q  <= scl_side;
      trk_pos_q   <= pos_val;
      trk_vel_q   <= vel_val[CFG_W-1:0];
      trk_trq_q   <= trq_val[CFG_W-1:0];

      mul_side_q  <= trk_side_q;
      mul_pos_q   <= trk_pos_q;
      mul_vel_q   <= trk_vel_q;
      mul_trq_q   <= trk_trq_q;
      mul_turns_q <= turns_q;
      mul_prod_q  <= (TURN_W+SPAN_W)'($signed(turns_q)) * (TURN_W+SPAN_W)'(pspan_q);

      out_q       <= res_d;
      out_mode_q  <= mul_side_q.mode;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MFD_ASSERT(a_stall_freezes_input, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while output stalled")
  `MFD_ASSERT(a_calib_result_zero, (m_axis_tvalid && out_mode_q) |-> (m_axis_tdata == '0), "calibration result not zero")
  `MFD_ASSERT_NEXT(a_turns_idle_hold, !(en && scl_v), $stable(turns_q), "turn counter moved without an item")
  `MFD_ASSERT(a_turns_single_step, (turns_q == $past(turns_q)) || (turns_q == $past(turns_q) + TURN_W'(1)) || (turns_q == $past(turns_q) - TURN_W'(1)) || (turns_q == '0), "turn counter jumped by more than one")

endmodule

[hw/rtl/mfd_scale.sv]
// Linear scaler: lo + trunc(raw * (hi - lo) / (2^BITS - 1)), four stages.
// Division by 2^BITS - 1 uses the geometric shift sum plus one correction.
module mfd_scale
  import mfd_pkg::*;
#(
  parameter int unsigned BITS = POS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [BITS-1:0]         raw_i,
  input  logic signed [CFG_W-1:0] lo_i,
  input  logic signed [CFG_W-1:0] hi_i,
  output logic signed [VAL_W-1:0] val_o
);

  localparam int unsigned PW = BITS + CFG_W;             // product width
  localparam int unsigned NT = (PW + BITS - 1) / BITS;   // shift-sum terms
  localparam int unsigned QW = PW - BITS + 1;            // first quotient estimate
  localparam logic [PW:0] DEN = (PW+1)'((64'd1 << BITS) - 64'd1);

  // span magnitude, refreshed every cycle (range registers are static in use)
  logic signed [SPAN_W-1:0] span;
  logic [CFG_W-1:0]         span_mag_d, span_mag_q;
  logic                     span_neg_q;

  assign span       = SPAN_W'(hi_i) - SPAN_W'(lo_i);
  assign span_mag_d = span[SPAN_W-1] ? CFG_W'(-span) : span[CFG_W-1:0];

  always_ff @(posedge clk_i) begin
    span_mag_q <= span_mag_d;
    span_neg_q <= span[SPAN_W-1];
  end

  // stage 1: magnitude product
  logic [PW-1:0] m_q;
  logic          neg1_q;

  // stage 2: quotient estimate, low by at most one
  logic [PW:0]   m_ext;
  logic [PW:0]   sum_d;
  logic [QW-1:0] q0_q;
  logic [PW-1:0] m2_q;
  logic          neg2_q;

  assign m_ext = {1'b0, m_q};

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NT; k++) begin
      sum_d = sum_d + (m_ext >> (k * BITS));
    end
  end

  // stage 3: remainder check
  logic [PW:0]      q0_ext;
  logic [PW:0]      rem;
  logic [CFG_W-1:0] q_d, q_q;
  logic             neg3_q;

  assign q0_ext = (PW+1)'(q0_q);
  assign rem    = {1'b0, m2_q} + q0_ext - (q0_ext << BITS);
  assign q_d    = q0_q[CFG_W-1:0] + CFG_W'(rem >= DEN);

  // stage 4: sign and offset
  logic signed [VAL_W-1:0] q_s;
  logic signed [VAL_W-1:0] val_d;

  assign q_s   = $signed(VAL_W'(q_q));
  assign val_d = VAL_W'(lo_i) + (neg3_q ? -q_s : q_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= PW'(raw_i) * PW'(span_mag_q);
      neg1_q <= span_neg_q;
      q0_q   <= sum_d[PW:BITS];
      m2_q   <= m_q;
      neg2_q <= neg1_q;
      q_q    <= q_d;
      neg3_q <= neg2_q;
      val_o  <= val_d;
    end
  end

endmodule

[dv/frame_decode_checker.sv]
module frame_decode_checker
  import mfd_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF,
  parameter int unsigned VEL_BITS = VEL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [FRAME_W-1:0]   in_frame_i,
  input  logic [0:0]           in_mode_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [RES_W-1:0]     out_data_i,

  output int                   pending_o,
  output int                   fail_count_o
);

  // shadow copy of the range registers
  logic signed [CFG_W-1:0] pos_min_q, pos_max_q;
  logic signed [CFG_W-1:0] vel_min_q, vel_max_q;
  logic signed [CFG_W-1:0] trq_min_q, trq_max_q;
  logic        [THR_W-1:0] wrap_thr_q;

  // turn tracking
  longint                  last_pos_q;
  logic signed [TURN_W-1:0] turns_q;

  result_t decoded_q[$];

  // min + (raw * span) / (2^bits - 1), quotient truncated toward zero
  function automatic longint scale_field(longint raw, longint lo, longint hi, int bits);
    longint denom;
    denom = (longint'(1) << bits) - 1;
    return lo + (raw * (hi - lo)) / denom;
  endfunction

  // expected result of one item; advances the turn state
  function automatic result_t decode_frame(mode_e mode, logic [FRAME_W-1:0] frame);
    result_t res;
    longint  pmin, pmax, thr, pos, vel, trq, diff, total;
    res = '0;
    if (mode == MODE_CALIB) begin
      turns_q    = '0;
      last_pos_q = 0;
      return res;
    end
    pmin = longint'(pos_min_q);
    pmax = longint'(pos_max_q);
    thr  = longint'(wrap_thr_q);
    pos  = scale_field(longint'(frame[55:40] >> (16 - POS_BITS)), pmin, pmax, POS_BITS);
    vel  = scale_field(longint'(frame[39:28] >> (12 - VEL_BITS)),
                       longint'(vel_min_q), longint'(vel_max_q), VEL_BITS);
    trq  = scale_field(longint'(frame[27:16]),
                       longint'(trq_min_q), longint'(trq_max_q), TRQ_BITS);
    diff = pos - last_pos_q;
    if (diff < -thr) begin
      turns_q = turns_q + 1;
    end else if (diff > thr) begin
      turns_q = turns_q - 1;
    end
    last_pos_q = pos;
    total = longint'(turns_q) * (pmax - pmin) + pos;

    res.motor_id    = frame[59:56];
    res.error_code  = frame[63:60];
    res.position    = pos[CFG_W-1:0];
    res.velocity    = vel[CFG_W-1:0];
    res.torque      = trq[CFG_W-1:0];
    res.mos_temp    = frame[15:8];
    res.rotor_temp  = frame[7:0];
    res.turn_count  = turns_q;
    res.total_angle = total[TOTAL_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic void compare_result(result_t want, result_t got);
    check_field("motor_id",    want.motor_id,    got.motor_id);
    check_field("error_code",  want.error_code,  got.error_code);
    check_field("position",    want.position,    got.position);
    check_field("velocity",    want.velocity,    got.velocity);
    check_field("torque",      want.torque,      got.torque);
    check_field("mos_temp",    want.mos_temp,    got.mos_temp);
    check_field("rotor_temp",  want.rotor_temp,  got.rotor_temp);
    check_field("turn_count",  want.turn_count,  got.turn_count);
    check_field("total_angle", want.total_angle, got.total_angle);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q    = POS_MIN_RST;
      pos_max_q    = POS_MAX_RST;
      vel_min_q    = VEL_MIN_RST;
      vel_max_q    = VEL_MAX_RST;
      trq_min_q    = TRQ_MIN_RST;
      trq_max_q    = TRQ_MAX_RST;
      wrap_thr_q   = THR_RST;
      last_pos_q   = 0;
      turns_q      = '0;
      decoded_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_POS_MIN:  pos_min_q  = cfg_data_i;
          CFG_POS_MAX:  pos_max_q  = cfg_data_i;
          CFG_VEL_MIN:  vel_min_q  = cfg_data_i;
          CFG_VEL_MAX:  vel_max_q  = cfg_data_i;
          CFG_TRQ_MIN:  trq_min_q  = cfg_data_i;
          CFG_TRQ_MAX:  trq_max_q  = cfg_data_i;
          CFG_WRAP_THR: wrap_thr_q = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      // results leave in order, so the oldest expectation is the match
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result item with no frame outstanding: %0h", out_data_i);
          fail_count_o++;
        end else begin
          compare_result(decoded_q.pop_front(), result_t'(out_data_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        decoded_q.push_back(decode_frame(mode_e'(in_mode_i), in_frame_i));
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

[dv/tb_motor_feedback_frame_decoder_core.sv]
module tb_motor_feedback_frame_decoder_core;
  import mfd_pkg::*;

  // Run length and timing
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned SETTLE_CYCLES = 16;      // longer than the pipeline
  localparam int unsigned CYCLE_LIMIT   = 600000;  // far above the slowest legal run

  // Range extremes for the 24-bit signed registers
  localparam logic [CFG_W-1:0] CFG_MOST_NEG = 24'h800000;
  localparam logic [CFG_W-1:0] CFG_MOST_POS = 24'h7FFFFF;

  logic                 clk_i;
  logic                 rst_ni;

  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [FRAME_W-1:0]   s_axis_tdata;   // [63:0] frame
  logic [0:0]           s_axis_tuser;   // [0] mode

  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [RES_W-1:0]     m_axis_tdata;   // motor_id, error_code, position, velocity,
                                        // torque, mos_temp, rotor_temp, turn_count,
                                        // total_angle (lowest bits first)

  int                   pending;
  int                   fail_count;

  // Sender-side idling control
  bit                   no_gaps;
  // Encoder-like position walk, so turn crossings happen the way a real shaft makes them
  logic [15:0]          walk_pos;

  motor_feedback_frame_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Watches all three channels, predicts each result and compares it
  frame_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_frame_i   (s_axis_tdata),
    .in_mode_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop if the pipeline hangs or results go missing
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: alternating ready runs and stalls. Most stalls are short,
  // some are long; some runs are long so the pipeline also streams unthrottled.
  initial begin
    bit          ready_now;
    int unsigned hold;
    ready_now = 1'b0;
    hold      = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        ready_now = !ready_now;
        if (ready_now) begin
          hold = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
        end else begin
          hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                               : $urandom_range(10, 40);
        end
      end else begin
        hold--;
      end
      m_axis_tready <= ready_now;
    end
  end

  // Byte 0, position, velocity, torque and the two temperature bytes, byte 0 on top
  function automatic logic [FRAME_W-1:0] pack_frame(logic [7:0] b0, logic [15:0] praw,
                                                    logic [11:0] vraw, logic [11:0] traw,
                                                    logic [7:0] mos, logic [7:0] rotor);
    return {b0, praw, vraw, traw, mos, rotor};
  endfunction

  // Sender gap: mostly none, often short, rarely a long pause
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random frame; packed fields sometimes pinned at all-zero or all-one,
  // and half the time the position follows the walk
  function automatic logic [FRAME_W-1:0] next_frame();
    logic [FRAME_W-1:0] fr;
    fr = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: fr[55:16] = '0;
      1: fr[55:16] = '1;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      walk_pos  = walk_pos + 16'(int'($urandom_range(0, 24000)) - 12000);
      fr[55:40] = walk_pos;
    end
    return fr;
  endfunction

  // Range bound: extremes, values near zero, or anything
  function automatic logic [CFG_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return CFG_MOST_NEG;
      1:       return CFG_MOST_POS;
      2:       return CFG_W'(int'($urandom_range(0, 131072)) - 65536);
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Threshold: zero, the top, full 24-bit noise (top bit is dropped), or typical
  function automatic logic [CFG_W-1:0] pick_thr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_MOST_POS;
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 2000000));
    endcase
  endfunction

  // One item; valid stays up across back-to-back items
  task automatic send_item(mode_e mode, logic [FRAME_W-1:0] frame);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= frame;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = no_gaps ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_ranges(logic [CFG_W-1:0] pmin, logic [CFG_W-1:0] pmax,
                             logic [CFG_W-1:0] vmin, logic [CFG_W-1:0] vmax,
                             logic [CFG_W-1:0] tmin, logic [CFG_W-1:0] tmax,
                             logic [CFG_W-1:0] thr);
    write_reg(CFG_POS_MIN,  pmin);
    write_reg(CFG_POS_MAX,  pmax);
    write_reg(CFG_VEL_MIN,  vmin);
    write_reg(CFG_VEL_MAX,  vmax);
    write_reg(CFG_TRQ_MIN,  tmin);
    write_reg(CFG_TRQ_MAX,  tmax);
    write_reg(CFG_WRAP_THR, thr);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait until every outstanding result has been checked;
  // every item yields a result, so the pipeline is empty after this
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      phase_len;
    logic [CFG_W-1:0] pmin, vmin, tmin;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_POS_MIN;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_FEEDBACK;
    no_gaps       = 1'b0;
    walk_pos      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset ranges (position +-12.5, velocity +-30, torque +-10, threshold 12.5)
    // all-zero frame: bottom of every range, jump equals the threshold -> no step
    send_item(MODE_FEEDBACK, '0);
    // all-one frame: top of every range, jump of a full span -> turn down
    send_item(MODE_FEEDBACK, '1);
    send_item(MODE_FEEDBACK, '0);
    send_item(MODE_FEEDBACK, pack_frame(8'hA5, 16'h8000, 12'h800, 12'h7FF, 8'h00, 8'hFF));
    // calibration ignores its frame and zeroes everything
    send_item(MODE_CALIB, '1);
    // from zero up to the top is exactly the threshold -> no step
    send_item(MODE_FEEDBACK, '1);
    send_item(MODE_CALIB, '0);
    // rising sawtooth in thirds: each fall back to zero counts one more turn
    for (int k = 0; k < 9; k++) begin
      send_item(MODE_FEEDBACK, pack_frame(8'h3C, 16'((k % 3) * 24576), 12'h5A5, 12'hA5A,
                                          8'h55, 8'hAA));
    end
    send_item(MODE_FEEDBACK, pack_frame(8'h5A, 16'h0001, 12'h001, 12'hFFE, 8'hFF, 8'h00));
    send_item(MODE_FEEDBACK, pack_frame(8'hF0, 16'hFFFE, 12'hFFF, 12'h000, 8'h80, 8'h01));

    // Random part, in phases with a new register setting each
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      case (phase)
        // widest ranges, every change of position is a turn step
        0: load_ranges(CFG_MOST_NEG, CFG_MOST_POS, CFG_MOST_NEG, CFG_MOST_POS,
                       CFG_MOST_NEG, CFG_MOST_POS, '0);
        // reversed ranges scale downward; largest threshold
        1: load_ranges(CFG_MOST_POS, CFG_MOST_NEG, CFG_MOST_POS, CFG_MOST_NEG,
                       CFG_MOST_POS, CFG_MOST_NEG, CFG_MOST_POS);
        // empty ranges: every packed value gives min
        2: begin
          pmin = pick_bound();
          vmin = pick_bound();
          tmin = pick_bound();
          load_ranges(pmin, pmin, vmin, vmin, tmin, tmin, pick_thr());
        end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            load_ranges(POS_MIN_RST, POS_MAX_RST, VEL_MIN_RST, VEL_MAX_RST,
                        TRQ_MIN_RST, TRQ_MAX_RST, CFG_W'(THR_RST));
          end else begin
            load_ranges(pick_bound(), pick_bound(), pick_bound(), pick_bound(),
                        pick_bound(), pick_bound(), pick_thr());
          end
        end
      endcase
      // some phases run without any sender gaps
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        send_item(($urandom_range(0, 19) == 0) ? MODE_CALIB : MODE_FEEDBACK, next_frame());
      end
      sent  += phase_len;
      phase++;
    end

    // Let everything drain, then watch a little longer for stray results
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
